### rtl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg - shelving biquad shared definitions
// Coefficient width, default parameter values and register indexes.
// ----------------------------------------------------------------------------
package sbq_pkg;

   localparam int COEF_BITS          = 32;
   localparam int DEF_SAMPLE_BITS    = 24;
   localparam int DEF_COEF_FRAC_BITS = 24;
   localparam int CSR_INDEX_BITS     = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FF0 = 3'd0,
      REG_FF1 = 3'd1,
      REG_FF2 = 3'd2,
      REG_FB1 = 3'd3,
      REG_FB2 = 3'd4
   } csr_reg_type;

endpackage

### rtl/shelving_biquad_filter_core.sv
// ----------------------------------------------------------------------------
// shelving_biquad_filter_core - direct form I biquad section
// Five coefficient products are summed exactly, rounded, saturated to the
// sample width and fed back through a two-deep input and output history.
// ----------------------------------------------------------------------------
// Result path: input register, then result register; a stalled result holds the
// request in the input register and stalls new requests.
// Throughput: 1 request per cycle while the result is not stalled; the output
// feedback closes through the multiply, sum and saturate path.
// Reset (synchronous, active high): history cleared, ff0 = 1.0, other
// coefficients zero, pipeline empty.
module shelving_biquad_filter_core
   import sbq_pkg::*;
#(
   parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
   parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_clipped,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [COEF_BITS-1:0]          csr_wdata
);

   localparam int ProdW = SAMPLE_BITS + COEF_BITS;
   localparam int AccW  = ProdW + 3;
   localparam logic signed [AccW-1:0] RoundBias = AccW'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [AccW-1:0] SatMax =
      {{(AccW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [AccW-1:0] SatMin = ~SatMax;
   localparam logic signed [COEF_BITS-1:0] UnityGain = COEF_BITS'(1) << COEF_FRAC_BITS;

   logic signed [COEF_BITS-1:0]   ff0_ff, ff1_ff, ff2_ff, fb1_ff, fb2_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff, x1_ff, x2_ff, y1_ff, y2_ff;
   logic                          s1_valid_ff, rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, y_in;
   logic                          rsp_clipped_ff, clip_in;
   logic                          advance;
   logic signed [ProdW-1:0]       p0, p1, p2, p3, p4;
   logic signed [AccW-1:0]        acc, acc_sh;

   assign csr_ready = 1'b1;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;

   // coefficients
   always_ff @(posedge clock) begin
      if (reset) begin
         ff0_ff <= UnityGain;
         ff1_ff <= '0;
         ff2_ff <= '0;
         fb1_ff <= '0;
         fb2_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FF0: ff0_ff <= csr_wdata;
            REG_FF1: ff1_ff <= csr_wdata;
            REG_FF2: ff2_ff <= csr_wdata;
            REG_FB1: fb1_ff <= csr_wdata;
            REG_FB2: fb2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         x_ff <= req_sample_in;
      end
   end

   always_comb begin
      p0     = x_ff * ff0_ff;
      p1     = x1_ff * ff1_ff;
      p2     = x2_ff * ff2_ff;
      p3     = y1_ff * fb1_ff;
      p4     = y2_ff * fb2_ff;
      acc    = AccW'(p0) + AccW'(p1) + AccW'(p2) + AccW'(p3) + AccW'(p4) + RoundBias;
      acc_sh = acc >>> COEF_FRAC_BITS;
      if (acc_sh > SatMax) begin
         y_in    = SatMax[SAMPLE_BITS-1:0];
         clip_in = 1'b1;
      end else if (acc_sh < SatMin) begin
         y_in    = SatMin[SAMPLE_BITS-1:0];
         clip_in = 1'b1;
      end else begin
         y_in    = acc_sh[SAMPLE_BITS-1:0];
         clip_in = 1'b0;
      end
   end

   // history
   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else if (s1_valid_ff && advance) begin
         x1_ff <= x_ff;
         x2_ff <= x1_ff;
         y1_ff <= y_in;
         y2_ff <= y1_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         rsp_sample_ff  <= y_in;
         rsp_clipped_ff <= clip_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clipped_ff;

endmodule

### rtl/sbq_checker.sv
// ----------------------------------------------------------------------------
// sbq_checker - port-level checks for the shelving biquad core
// Result handshake, saturation flag, reset and backpressure relations.
// ----------------------------------------------------------------------------
module sbq_checker
   import sbq_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                          rsp_clipped
);

   localparam logic signed [SAMPLE_BITS-1:0] SampleMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SampleMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_sample_out) && $stable(rsp_clipped))
      else $error("stalled result changed");

   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> rsp_sample_out == SampleMax || rsp_sample_out == SampleMin)
      else $error("clipped result not at a rail");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without result backpressure");

endmodule

bind shelving_biquad_filter_core sbq_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sbq_checker (.*);
